@@ design/sha_pkg.sv @@
`timescale 1ns / 1ps
package sha_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_EMIT
	} eng_state_t;

	typedef struct packed {
		logic       is_end;
		logic [7:0] data;
	} cmd_t;

	localparam int CmdQDepth = 2;
	localparam int CmdQAw    = 1;

	localparam logic [7:0] PAD_MARK = 8'h80;

	function automatic logic [31:0] init_word(input logic [2:0] i);
		logic [31:0] r;
		unique case (i)
			3'd0: r = 32'h6A09E667;
			3'd1: r = 32'hBB67AE85;
			3'd2: r = 32'h3C6EF372;
			3'd3: r = 32'hA54FF53A;
			3'd4: r = 32'h510E527F;
			3'd5: r = 32'h9B05688C;
			3'd6: r = 32'h1F83D9AB;
			default: r = 32'h5BE0CD19;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] round_const(input logic [5:0] t);
		logic [31:0] k [64];
		k = '{
			32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
			32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
			32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
			32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
			32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
			32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
			32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
			32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
			32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
			32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
			32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
			32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
			32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
			32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
			32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
			32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
		};
		return k[t];
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

@@ design/sha256_message_hasher_core.sv @@
`timescale 1ns / 1ps
// channel | ports                        | handshake
// input   | kind, byte_value             | push / full
// result  | digest_word, word_index, last_word | pop / empty
// a data word is taken while idle; a word that fills a block runs 64 rounds before the next word is taken
// an end word pads and compresses one or two blocks before the eight result words appear
// results are held in the chaining registers and leave one per pop
// a two-entry queue decouples the input from the round engine
// arst_n restores the initial hash values and clears the bit counter
module sha256_message_hasher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        kind,
	input  logic [7:0]  byte_value,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import sha_pkg::*;

	cmd_t in_cmd, head;
	logic q_empty, take;

	assign in_cmd.is_end = kind;
	assign in_cmd.data   = byte_value;

	sha_cmd_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_cmd(in_cmd), .full(full),
		.pop(take), .head_cmd(head), .empty(q_empty)
	);

	sha_engine u_engine (
		.clk(clk), .arst_n(arst_n), .cmd(head), .cmd_valid(!q_empty), .cmd_take(take),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word),
		.empty(empty), .pop(pop)
	);
endmodule

@@ design/sha_cmd_queue.sv @@
`timescale 1ns / 1ps
module sha_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sha_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output sha_pkg::cmd_t head_cmd,
	output logic          empty
);
	import sha_pkg::*;

	cmd_t              slot_q [CmdQDepth];
	logic [CmdQAw-1:0] wr_q, rd_q;
	logic [CmdQAw:0]   cnt_q;
	logic              do_push, do_pop;

	assign full     = (cnt_q == (CmdQAw+1)'(CmdQDepth));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_cmd = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (CmdQAw+1)'(do_push) - (CmdQAw+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_q] <= push_cmd;
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= (CmdQAw+1)'(CmdQDepth))
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n) (pop && !empty && !push) |=> !full)
		else $error("full after pop");
	assert property (@(posedge clk) disable iff (!arst_n) empty |-> (wr_q == rd_q))
		else $error("pointers differ while empty");
endmodule

@@ design/sha_engine.sv @@
`timescale 1ns / 1ps
module sha_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  sha_pkg::cmd_t cmd,
	input  logic          cmd_valid,
	output logic          cmd_take,
	output logic [31:0]   digest_word,
	output logic [2:0]    word_index,
	output logic          last_word,
	output logic          empty,
	input  logic          pop
);
	import sha_pkg::*;

	eng_state_t  state_q, state_d;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [63:0] len_q;
	logic [5:0]  t_q;
	logic [2:0]  idx_q;
	logic        final_q;
	logic        pad2_q;
	logic [5:0]  used;
	logic [31:0] wt, s0, s1, t1, t2, w_new;
	logic        take_data, take_end, round_last;

	assign used = len_q[8:3];
	assign round_last = (t_q == 6'd63);

	always_comb begin
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = w_q[0] + s0 + w_q[9] + s1;
		wt = w_q[0];
		t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_const(t_q) + wt;
		t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid && !cmd.is_end && used == 6'd63) state_d = ST_ROUND;
				else if (cmd_valid && cmd.is_end) state_d = ST_PAD;
			end
			ST_PAD:   state_d = ST_ROUND;
			ST_ROUND: if (round_last) state_d = ST_ADD;
			ST_ADD: begin
				if (pad2_q) state_d = ST_PAD;
				else if (final_q) state_d = ST_EMIT;
				else state_d = ST_IDLE;
			end
			ST_EMIT:  if (pop && idx_q == 3'd7) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		take_data = (state_q == ST_IDLE) && cmd_valid && !cmd.is_end;
		take_end  = (state_q == ST_IDLE) && cmd_valid && cmd.is_end;
		cmd_take  = take_data || take_end;
		empty     = (state_q != ST_EMIT);
		digest_word = h_q[idx_q];
		word_index  = idx_q;
		last_word   = (idx_q == 3'd7);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q   <= '0;
			t_q     <= '0;
			idx_q   <= '0;
			final_q <= 1'b0;
			pad2_q  <= 1'b0;
			for (int i = 0; i < 8; i++) h_q[i] <= init_word(3'(i));
			for (int i = 0; i < 8; i++) v_q[i] <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					t_q <= '0;
					if (take_data) begin
						len_q <= len_q + 64'd8;
						for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
					end
					if (take_end) begin
						final_q <= 1'b1;
						pad2_q  <= (used >= 6'd56);
					end
				end
				ST_PAD: begin
					t_q <= '0;
					for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
				end
				ST_ROUND: begin
					v_q[7] <= v_q[6];
					v_q[6] <= v_q[5];
					v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2];
					v_q[2] <= v_q[1];
					v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
					t_q <= t_q + 6'd1;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					idx_q  <= '0;
					pad2_q <= 1'b0;
				end
				ST_EMIT: begin
					if (pop) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							final_q <= 1'b0;
							len_q   <= '0;
							for (int i = 0; i < 8; i++) h_q[i] <= init_word(3'(i));
						end
					end
				end
				default: ;
			endcase
		end
	end

	// message schedule as a 16-word shift line, loaded bytewise then rolled per round
	always_ff @(posedge clk) begin
		if (take_data) begin
			w_q[used[5:2]] <= (w_q[used[5:2]] & ~(32'hFF << (8 * (3 - used[1:0]))))
				| (32'(cmd.data) << (8 * (3 - used[1:0])));
		end else if (take_end) begin
			for (int i = 0; i < 16; i++) begin
				if (6'(i * 4) > used) w_q[i] <= '0;
				else if (6'(i * 4 + 3) >= used) begin
					w_q[i] <= (w_q[i] & ~(32'hFFFFFFFF >> (8 * used[1:0])))
						| (32'(PAD_MARK) << (8 * (3 - used[1:0])));
				end
			end
		end else if (state_q == ST_ADD && pad2_q) begin
			for (int i = 0; i < 16; i++) w_q[i] <= '0;
		end else if (state_q == ST_PAD && !pad2_q) begin
			w_q[14] <= len_q[63:32];
			w_q[15] <= len_q[31:0];
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && !round_last) |=> state_q == ST_ROUND)
		else $error("round sequence broken");
	assert property (@(posedge clk) disable iff (!arst_n) (state_q == ST_EMIT) |-> final_q)
		else $error("emit without end word");
	assert property (@(posedge clk) disable iff (!arst_n) cmd_take |-> cmd_valid)
		else $error("take without queued word");
endmodule

@@ verif/tb_sha256_message_hasher_core.sv @@
`timescale 1ns / 1ps
module tb_sha256_message_hasher_core;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic        kind;
	logic [7:0]  byte_value;
	logic        empty;
	logic        pop;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;
	localparam int   IDLE_LIMIT = 20000;

	typedef struct {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_out_t;

	class sha256_scoreboard;
		logic [31:0] chain [8];
		logic [7:0]  blk [64];
		logic [63:0] nbits;
		digest_out_t pending_words [$];
		int          errors;

		function new();
			errors = 0;
			restart();
		endfunction

		function void restart();
			for (int i = 0; i < 8; i++)
				chain[i] = sha_pkg::init_word(i[2:0]);
			nbits = '0;
		endfunction

		function logic [31:0] rr(logic [31:0] x, int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function void compress();
			logic [31:0] w [16];
			logic [31:0] v [8];
			logic [31:0] s0, s1, t1, t2;
			for (int i = 0; i < 16; i++)
				w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
			for (int i = 0; i < 8; i++)
				v[i] = chain[i];
			for (int t = 0; t < 64; t++) begin
				if (t >= 16) begin
					s0 = rr(w[(t+1)&15], 7) ^ rr(w[(t+1)&15], 18) ^ (w[(t+1)&15] >> 3);
					s1 = rr(w[(t+14)&15], 17) ^ rr(w[(t+14)&15], 19) ^ (w[(t+14)&15] >> 10);
					w[t&15] = w[t&15] + s0 + w[(t+9)&15] + s1;
				end
				t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::round_const(t[5:0]) + w[t&15];
				t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
				v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++)
				chain[i] = chain[i] + v[i];
		endfunction

		function void note_word(logic k, logic [7:0] b);
			int used;
			digest_out_t d;
			used = int'(nbits[8:3]);
			if (k == KIND_DATA) begin
				blk[used] = b;
				nbits = nbits + 64'd8;
				if (used == 63)
					compress();
				return;
			end
			blk[used] = sha_pkg::PAD_MARK;
			used++;
			if (used > 56) begin
				for (int i = used; i < 64; i++)
					blk[i] = '0;
				compress();
				used = 0;
			end
			for (int i = used; i < 56; i++)
				blk[i] = '0;
			for (int i = 0; i < 8; i++)
				blk[56+i] = nbits[63-8*i -: 8];
			compress();
			for (int i = 0; i < 8; i++) begin
				d.digest_word = chain[i];
				d.word_index  = i[2:0];
				d.last_word   = (i == 7);
				pending_words.push_back(d);
			end
			restart();
		endfunction

		function void check_word(logic [31:0] dw, logic [2:0] wi, logic lw);
			digest_out_t e;
			if (pending_words.size() == 0) begin
				$error("unexpected word digest_word=%h", dw);
				errors++;
				return;
			end
			e = pending_words.pop_front();
			if (dw !== e.digest_word) begin
				$error("digest_word expected %h actual %h", e.digest_word, dw);
				errors++;
			end
			if (wi !== e.word_index) begin
				$error("word_index expected %0d actual %0d", e.word_index, wi);
				errors++;
			end
			if (lw !== e.last_word) begin
				$error("last_word expected %0d actual %0d", e.last_word, lw);
				errors++;
			end
		endfunction
	endclass

	sha256_scoreboard sb;
	int  idle_cycles;
	bit  calm;
	bit  hold_off;

	sha256_message_hasher_core dut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		kind = KIND_DATA;
		byte_value = '0;
		calm = 0;
		hold_off = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// acceptance bookkeeping and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (push && !full)
				sb.note_word(kind, byte_value);
			if (pop && !empty)
				sb.check_word(digest_word, word_index, last_word);
			if (idle_cycles > IDLE_LIMIT) begin
				$display("tb_sha256_message_hasher_core: FAIL");
				$finish;
			end
		end else
			idle_cycles <= 0;
	end

	task automatic send_word(logic k, logic [7:0] b);
		while (!calm && $urandom_range(99) < 20) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		kind <= k;
		byte_value <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_message(int n);
		for (int i = 0; i < n; i++)
			send_word(KIND_DATA, 8'($urandom));
		send_word(KIND_END, 8'($urandom));
	endtask

	// receiver
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				pop <= 1'b0;
				repeat (600) @(negedge clk);
				hold_off = 0;
			end else
				pop <= calm || ($urandom_range(99) >= 20);
		end
	end

	initial begin
		int sent;
		@(posedge arst_n);
		@(negedge clk);
		// empty message, ignored byte on end words
		send_word(KIND_END, 8'hFF);
		send_message(0);
		send_word(KIND_DATA, 8'h00);
		send_word(KIND_DATA, 8'hFF);
		send_word(KIND_END, 8'h5A);
		// boundary lengths around the length field and the block
		send_message(55);
		send_message(56);
		send_message(63);
		send_message(64);
		sent = 247;
		// receiver stalls while messages keep arriving
		hold_off = 1;
		for (int m = 0; m < 4; m++)
			send_message(2);
		sent += 12;
		// long stretch with no idling on either side
		calm = 1;
		send_message(80);
		send_message(40);
		calm = 0;
		sent += 122;
		while (sent < 480) begin
			int n;
			n = ($urandom_range(9) == 0) ? $urandom_range(70, 130) : $urandom_range(0, 20);
			send_message(n);
			sent += n + 1;
		end
		push <= 1'b0;
		while (sb.pending_words.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending_words.size() == 0)
			$display("tb_sha256_message_hasher_core: PASS");
		else
			$display("tb_sha256_message_hasher_core: FAIL");
		$finish;
	end

endmodule
